>>> design/tcce_pkg.sv
// Package for the text console cursor engine: command kinds, character codes,
// sequencer states and reset values. No dependencies.
package tcce_pkg;

  typedef enum logic [2:0] {
    KIND_PUT   = 3'd0,
    KIND_SETC  = 3'd1,
    KIND_CLEAR = 3'd2,
    KIND_BOX   = 3'd3,
    KIND_READ  = 3'd4
  } kind_e;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] ATTR_RST = 8'h0F;

  typedef enum logic [3:0] {
    ST_INIT,    // reset sweep: write blanks everywhere
    ST_IDLE,
    ST_FILL,    // write blanks over a cell range
    ST_SCRL_RD, // read the cell one row below
    ST_SCRL_WR, // write it one row up
    ST_BOX,     // walk the box cells
    ST_RD_WAIT,
    ST_RD_DATA,
    ST_OUT
  } state_e;

endpackage

>>> design/text_console_cursor_engine.sv
// Top level of the text console cursor engine: screen memory, cursor and the
// sequencer that walks it. Depends on tcce_pkg.
//
// After reset the block sweeps the whole screen with white-on-black blanks,
// one cell a cycle, before it takes its first word. Every word is accepted in
// the idle state and goes on to the output state; a read passes through a
// wait state and a data state on the way. Work that walks the cell memory
// adds to that: a clear blanks every cell, one a cycle; a scroll reads each
// cell below the top row and writes it one row up, then blanks the last row;
// a box writes each cell of its bounding rectangle, one a cycle (a zero width
// still writes one cell a row, a zero height one row).
// The result is held in an output register until taken; the next word is taken
// only after that.
module text_console_cursor_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] col_i,
  input  logic [4:0] row_i,
  input  logic [6:0] box_width_i,
  input  logic [4:0] box_height_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [6:0] LASTC = 7'(COLUMNS - 1);
  localparam logic [4:0] LASTR = 5'(ROWS - 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  logic [15:0] mem [CELLS];
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  state_e st_q, st_d;
  logic [7:0] attr_q;
  logic [6:0] ccol_q, ccol_d;
  logic [4:0] crow_q, crow_d;
  logic [AW-1:0] ptr_q, ptr_d, end_q, end_d;
  logic [6:0] bw_q, bw_d, bi_q, bi_d;
  logic [4:0] bh_q, bh_d, bj_q, bj_d;
  logic [AW-1:0] rowbase_q, rowbase_d;
  logic [7:0] och_q, och_d, oat_q, oat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_INIT;
      attr_q <= ATTR_RST;
      ccol_q <= '0;
      crow_q <= '0;
      ptr_q  <= '0;
      end_q  <= AW'(CELLS - 1);
    end else begin
      st_q   <= st_d;
      if (cfg_we_i) attr_q <= cfg_data_i;
      ccol_q <= ccol_d;
      crow_q <= crow_d;
      ptr_q  <= ptr_d;
      end_q  <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bw_q <= bw_d; bi_q <= bi_d;
    bh_q <= bh_d; bj_q <= bj_d; rowbase_q <= rowbase_d;
    och_q <= och_d; oat_q <= oat_d;
  end

  // combinational helpers
  logic [6:0] cc, bwc;
  logic [7:0] tabc;
  logic [4:0] rr, bhc;
  logic [7:0] sumc;
  logic [5:0] sumr;
  logic [AW-1:0] cur_addr, in_addr;
  logic [7:0] boxch;
  logic bfirst_c, blast_c, bfirst_r, blast_r;

  assign cc   = (col_i >= 7'(COLUMNS)) ? LASTC : col_i;
  assign rr   = (5'(ROWS) <= row_i) ? LASTR : row_i;
  // one bit wider so a tab near column 127 cannot wrap round to zero
  assign tabc = ({1'b0, ccol_q} + 8'd8) & ~8'd7;
  assign sumc = {1'b0, col_i} + {1'b0, box_width_i};
  assign sumr = {1'b0, row_i} + {1'b0, box_height_i};
  assign bwc  = (sumc > 8'(COLUMNS)) ? 7'(8'(COLUMNS) - {1'b0, col_i}) : box_width_i;
  assign bhc  = (sumr > 6'(ROWS)) ? 5'(6'(ROWS) - {1'b0, row_i}) : box_height_i;
  assign cur_addr = AW'(crow_q * COLS_A) + AW'(ccol_q);
  assign in_addr  = AW'(rr * COLS_A) + AW'(cc);

  // box cell character from its position inside the box
  assign bfirst_c = (bi_q == 7'd0);
  assign blast_c  = (bi_q == bw_q - 7'd1) && (bw_q > 7'd1);
  assign bfirst_r = (bj_q == 5'd0);
  assign blast_r  = (bj_q == bh_q - 5'd1) && (bh_q > 5'd1);
  always_comb begin
    if (bfirst_r || blast_r) boxch = (bfirst_c || blast_c) ? CH_PLUS : CH_DASH;
    else                     boxch = (bfirst_c || blast_c) ? CH_BAR : CH_SPACE;
  end

  assign in_stall_o   = (st_q != ST_IDLE);
  assign out_valid_o  = (st_q == ST_OUT);
  assign cursor_col_o = ccol_q;
  assign cursor_row_o = crow_q;
  assign cell_char_o  = och_q;
  assign cell_attr_o  = oat_q;

  always_comb begin
    st_d = st_q; ccol_d = ccol_q; crow_d = crow_q;
    ptr_d = ptr_q; end_d = end_q;
    bw_d = bw_q; bi_d = bi_q; bh_d = bh_q; bj_d = bj_q;
    rowbase_d = rowbase_q; och_d = och_q; oat_d = oat_q;
    we = 1'b0; waddr = ptr_q; wdata = {attr_q, CH_SPACE}; raddr = ptr_q;
    unique case (st_q)
      ST_INIT: begin
        we = 1'b1; wdata = {ATTR_RST, CH_SPACE};
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == end_q) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          och_d = '0; oat_d = '0;
          st_d = ST_OUT;
          case (kind_i)
            KIND_PUT: begin
              if (char_code_i == CH_NL || char_code_i == CH_TAB && tabc >= 8'(COLUMNS)) begin
                ccol_d = '0;
                if (crow_q == LASTR) begin
                  ptr_d = '0; st_d = ST_SCRL_RD;
                end else crow_d = crow_q + 5'd1;
              end else if (char_code_i == CH_CR) begin
                ccol_d = '0;
              end else if (char_code_i == CH_TAB) begin
                ccol_d = tabc[6:0];
              end else if (char_code_i == CH_BS) begin
                if (ccol_q != '0) begin
                  ccol_d = ccol_q - 7'd1;
                  we = 1'b1; waddr = cur_addr - AW'(1);
                end else if (crow_q != '0) begin
                  crow_d = crow_q - 5'd1; ccol_d = LASTC;
                  we = 1'b1; waddr = cur_addr - AW'(1);
                end
              end else begin
                we = 1'b1; waddr = cur_addr; wdata = {attr_q, char_code_i};
                if (ccol_q == LASTC) begin
                  ccol_d = '0;
                  if (crow_q == LASTR) begin
                    ptr_d = '0; st_d = ST_SCRL_RD;
                  end else crow_d = crow_q + 5'd1;
                end else ccol_d = ccol_q + 7'd1;
              end
            end
            KIND_SETC: begin
              ccol_d = cc; crow_d = rr;
            end
            KIND_CLEAR: begin
              ccol_d = '0; crow_d = '0;
              ptr_d = '0; end_d = AW'(CELLS - 1); st_d = ST_FILL;
            end
            KIND_BOX: begin
              if (col_i < 7'(COLUMNS) && row_i < 5'(ROWS)) begin
                ccol_d = col_i; crow_d = row_i;
                bw_d = bwc; bh_d = bhc;
                bi_d = '0; bj_d = '0;
                rowbase_d = AW'(row_i * COLS_A) + AW'(col_i);
                st_d = ST_BOX;
              end
            end
            KIND_READ: begin
              ptr_d = in_addr; st_d = ST_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      ST_RD_WAIT: st_d = ST_RD_DATA;
      ST_RD_DATA: begin
        och_d = rdata_q[7:0]; oat_d = rdata_q[15:8]; st_d = ST_OUT;
      end
      ST_FILL: begin
        we = 1'b1;
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == end_q) st_d = ST_OUT;
      end
      ST_SCRL_RD: begin
        raddr = ptr_q + COLS_A; // data arrives next cycle
        st_d = ST_SCRL_WR;
      end
      ST_SCRL_WR: begin
        we = 1'b1; wdata = rdata_q;
        ptr_d = ptr_q + AW'(1);
        if (ptr_q == AW'(CELLS - COLUMNS - 1)) begin
          end_d = AW'(CELLS - 1); st_d = ST_FILL;
        end else st_d = ST_SCRL_RD;
      end
      ST_BOX: begin
        // origin corner always written, even for zero size
        we = 1'b1; waddr = rowbase_q + AW'(bi_q); wdata = {attr_q, boxch};
        if (bi_q + 7'd1 >= bw_q) begin
          bi_d = '0;
          bj_d = bj_q + 5'd1;
          rowbase_d = rowbase_q + COLS_A;
          if (bj_q + 5'd1 >= bh_q) st_d = ST_OUT;
        end else bi_d = bi_q + 7'd1;
      end
      ST_OUT: if (!out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

endmodule

>>> tb/tb_text_console_cursor_engine.sv
// Testbench for text_console_cursor_engine: directed and random command words
// checked against a cell-level screen predictor. Depends on tcce_pkg and the RTL.
module tb_text_console_cursor_engine;
  import tcce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 80;
  localparam int ROWS_N = 25;
  localparam int CELLS = COLS * ROWS_N;
  localparam int IDLE_LIMIT = 40000;
  localparam logic [2:0] KIND_SPARE = 3'd5;

  typedef struct packed {
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] ch;
    logic [7:0] at;
  } cursor_word_t;

  logic       clk_i, rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i, in_stall_o;
  logic [2:0] kind_i;
  logic [7:0] char_code_i;
  logic [6:0] col_i;
  logic [4:0] row_i;
  logic [6:0] box_width_i;
  logic [4:0] box_height_i;
  logic       out_valid_o, out_stall_i;
  logic [6:0] cursor_col_o;
  logic [4:0] cursor_row_o;
  logic [7:0] cell_char_o, cell_attr_o;

  text_console_cursor_engine u_top (.*);

  // screen shadow
  logic [15:0] shadow_cells [CELLS];
  int          pos_col, pos_row;
  logic [7:0]  cur_attr;

  cursor_word_t pending_words [$];
  int errors, results_seen, words_sent, scrolls, boxes, reads;
  int burst_left, hold_start, idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic void poke(int c, int r, logic [7:0] ch);
    if (c < COLS && r < ROWS_N) shadow_cells[r * COLS + c] = {cur_attr, ch};
  endfunction

  function automatic void advance_row();
    pos_col = 0;
    pos_row++;
    if (pos_row >= ROWS_N) begin
      for (int i = 0; i + COLS < CELLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int c = 0; c < COLS; c++) poke(c, ROWS_N - 1, CH_SPACE);
      pos_row = ROWS_N - 1;
      scrolls++;
    end
  endfunction

  function automatic void put_glyph(logic [7:0] ch);
    if (ch == CH_NL) advance_row();
    else if (ch == CH_CR) pos_col = 0;
    else if (ch == CH_TAB) begin
      pos_col = (pos_col + 8) & ~7;
      if (pos_col >= COLS) advance_row();
    end else if (ch == CH_BS) begin
      if (pos_col > 0) begin
        pos_col--;
        poke(pos_col, pos_row, CH_SPACE);
      end else if (pos_row > 0) begin
        pos_row--;
        pos_col = COLS - 1;
        poke(pos_col, pos_row, CH_SPACE);
      end
    end else begin
      poke(pos_col, pos_row, ch);
      pos_col++;
      if (pos_col >= COLS) advance_row();
    end
  endfunction

  function automatic void box_edge_row(int x, int r, int w, logic [7:0] corner,
                                       logic [7:0] mid);
    poke(x, r, corner);
    for (int i = 1; i < w - 1; i++) poke(x + i, r, mid);
    if (w > 1) poke(x + w - 1, r, corner);
  endfunction

  function automatic void draw_frame(int x, int y, int w, int h);
    if (x >= COLS || y >= ROWS_N) return;
    if (x + w > COLS) w = COLS - x;
    if (y + h > ROWS_N) h = ROWS_N - y;
    pos_col = x;
    pos_row = y;
    boxes++;
    box_edge_row(x, y, w, CH_PLUS, CH_DASH);
    for (int j = 1; j < h - 1; j++) begin
      poke(x, y + j, CH_BAR);
      for (int i = 1; i < w - 1; i++) poke(x + i, y + j, CH_SPACE);
      if (w > 1) poke(x + w - 1, y + j, CH_BAR);
    end
    if (h > 1) box_edge_row(x, y + h - 1, w, CH_PLUS, CH_DASH);
  endfunction

  function automatic cursor_word_t console_step(logic [2:0] k, logic [7:0] ch,
      logic [6:0] c, logic [4:0] r, logic [6:0] bw, logic [4:0] bh);
    cursor_word_t res;
    int cc, rr;
    cc = (c >= COLS) ? COLS - 1 : int'(c);
    rr = (r >= ROWS_N) ? ROWS_N - 1 : int'(r);
    res.ch = '0;
    res.at = '0;
    case (k)
      KIND_PUT:  put_glyph(ch);
      KIND_SETC: begin
        pos_col = cc;
        pos_row = rr;
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {cur_attr, CH_SPACE};
        pos_col = 0;
        pos_row = 0;
      end
      KIND_BOX:  draw_frame(int'(c), int'(r), int'(bw), int'(bh));
      KIND_READ: begin
        {res.at, res.ch} = shadow_cells[rr * COLS + cc];
        reads++;
      end
      default: ;
    endcase
    res.col = pos_col[6:0];
    res.row = pos_row[4:0];
    return res;
  endfunction

  // Send one word; bursts with random gaps in between.
  task automatic send_word(logic [2:0] k, logic [7:0] ch, logic [6:0] c,
                           logic [4:0] r, logic [6:0] bw, logic [4:0] bh);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    char_code_i  <= ch;
    col_i        <= c;
    row_i        <= r;
    box_width_i  <= bw;
    box_height_i <= bh;
    do @(posedge clk_i); while (in_stall_o);
    pending_words.push_back(console_step(k, ch, c, r, bw, bh));
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_words.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_attr(logic [7:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_attr = v;
  endtask

  task automatic send_random();
    int sel;
    logic [7:0] ch;
    sel = $urandom_range(0, 99);
    ch = 8'($urandom_range(32, 255));
    if (sel < 50) begin
      case ($urandom_range(0, 19))
        0: ch = CH_NL;
        1: ch = CH_CR;
        2: ch = CH_TAB;
        3, 4: ch = CH_BS;
        5: ch = 8'($urandom_range(0, 31));
        default: ;
      endcase
      send_word(KIND_PUT, ch, 7'($urandom), 5'($urandom), 7'($urandom), 5'($urandom));
    end else if (sel < 66) begin
      send_word(KIND_SETC, ch, 7'($urandom_range(0, 127)),
                5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 22)),
                7'($urandom), 5'($urandom));
    end else if (sel < 90) begin
      send_word(KIND_READ, ch, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                7'($urandom), 5'($urandom));
    end else if (sel < 95) begin
      send_word(KIND_BOX, ch, 7'($urandom_range(0, 90)), 5'($urandom_range(0, 27)),
                7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, 8)),
                5'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 5)));
    end else if (sel < 97) begin
      send_word(3'(KIND_SPARE + $urandom_range(0, 2)), ch, 7'($urandom), 5'($urandom),
                7'($urandom), 5'($urandom));
    end else if (sel < 98) begin
      send_word(KIND_CLEAR, ch, 7'($urandom), 5'($urandom), 7'($urandom), 5'($urandom));
    end else begin
      send_word(KIND_PUT, 8'($urandom_range(32, 126)), 0, 0, 0, 0);
    end
  endtask

  task automatic test_directed();
    send_word(KIND_READ, 0, 0, 0, 0, 0);
    send_word(KIND_PUT, 8'h41, 0, 0, 0, 0);
    send_word(KIND_PUT, 8'hFF, 0, 0, 0, 0);
    send_word(KIND_PUT, CH_TAB, 0, 0, 0, 0);
    send_word(KIND_PUT, CH_CR, 0, 0, 0, 0);
    send_word(KIND_PUT, CH_BS, 0, 0, 0, 0);    // top left: no-op
    send_word(KIND_PUT, CH_NL, 0, 0, 0, 0);
    send_word(KIND_PUT, CH_BS, 0, 0, 0, 0);    // wrap to row above
    send_word(KIND_SETC, 0, 7'd127, 5'd31, 0, 0);
    send_word(KIND_PUT, 8'h5A, 0, 0, 0, 0);    // last cell: scroll
    send_word(KIND_SETC, 0, 7'd76, 5'd24, 0, 0);
    send_word(KIND_PUT, CH_TAB, 0, 0, 0, 0);   // tab past last column
    send_word(KIND_PUT, CH_NL, 0, 0, 0, 0);
    send_word(KIND_READ, 0, 7'd127, 5'd31, 0, 0);
    send_word(KIND_READ, 0, 7'd0, 5'd23, 0, 0);
    send_word(KIND_BOX, 0, 7'd80, 5'd3, 7'd4, 5'd4);    // off screen
    send_word(KIND_BOX, 0, 7'd3, 5'd25, 7'd4, 5'd4);
    send_word(KIND_BOX, 0, 7'd2, 5'd2, 7'd0, 5'd0);
    send_word(KIND_BOX, 0, 7'd5, 5'd5, 7'd1, 5'd1);
    send_word(KIND_BOX, 0, 7'd75, 5'd20, 7'd127, 5'd31); // cut at edges
    send_word(KIND_READ, 0, 7'd79, 5'd24, 0, 0);
    send_word(KIND_READ, 0, 7'd76, 5'd21, 0, 0);
    send_word(KIND_SPARE, 8'hFF, 7'd127, 5'd31, 7'd127, 5'd31);
    send_word(3'd7, 0, 0, 0, 0, 0);
    send_word(KIND_CLEAR, 0, 0, 0, 0, 0);
  endtask

  task automatic test_attr_sweep();
    logic [7:0] vals [4] = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
    foreach (vals[i]) begin
      write_attr(vals[i]);
      repeat (20) send_random();
      send_word(KIND_PUT, 8'h33, 0, 0, 0, 0);
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 299) write_attr(8'($urandom));
      send_random();
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_start = 1;
    repeat (30) send_random();
    drain();
    repeat (30) send_random();
  endtask

  // Receiver: stalls at a randomly re-drawn rate of 0, 35 or 70 percent; long hold-off on request.
  initial begin
    int hold_cnt, cyc, pct;
    hold_cnt = 0;
    cyc = 0;
    pct = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 256 == 0) pct = $urandom_range(0, 2) * 35;
      if (hold_start) begin
        hold_start = 0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cursor_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("MISMATCH unexpected result (result %0d)", results_seen);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (cursor_col_o !== want.col)
          report("cursor_col", 8'(cursor_col_o), 8'(want.col));
        if (cursor_row_o !== want.row)
          report("cursor_row", 8'(cursor_row_o), 8'(want.row));
        if (cell_char_o !== want.ch) report("cell_char", cell_char_o, want.ch);
        if (cell_attr_o !== want.at) report("cell_attr", cell_attr_o, want.at);
      end
      results_seen++;
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_text_console_cursor_engine failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = '0;
    char_code_i = '0;
    col_i = '0;
    row_i = '0;
    box_width_i = '0;
    box_height_i = '0;
    errors = 0;
    results_seen = 0;
    words_sent = 0;
    scrolls = 0;
    boxes = 0;
    reads = 0;
    burst_left = 0;
    hold_start = 0;
    cur_attr = ATTR_RST;
    pos_col = 0;
    pos_row = 0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = {ATTR_RST, CH_SPACE};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_attr_sweep();
    test_backpressure();
    test_random(1250);
    drain();
    repeat (50) @(posedge clk_i);

    $display("Covered %0d words: %0d scrolls, %0d boxes drawn, %0d cell reads.",
             words_sent, scrolls, boxes, reads);
    if (errors == 0) $display("tb_text_console_cursor_engine passed");
    else $display("tb_text_console_cursor_engine failed");
    $finish;
  end

endmodule
